// ----- rtl/core/mctt_pkg.sv -----
package mctt_pkg;

    // Table geometry
    localparam int NUM_TIMERS  = 4;
    localparam int MAX_RESULTS = 4;
    localparam int IDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Field widths
    localparam int CLIENT_W = 8;
    localparam int DELAY_W  = 24;
    localparam int TIME_W   = 32;
    localparam int STEP_W   = 8;

    localparam logic [STEP_W-1:0] TICK_STEP_RESET = 8'd5;

    // Item codes
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_REG  = 1'b1;
    localparam logic KIND_PING = 1'b0;
    localparam logic KIND_FULL = 1'b1;

    typedef struct packed {
        logic                mode;
        logic [CLIENT_W-1:0] client_id;
        logic [DELAY_W-1:0]  delay_ms;
        logic                repeat_req;
    } t_in_item;

    typedef struct packed {
        logic                kind;
        logic [CLIENT_W-1:0] target_client;
        logic [TIME_W-1:0]   due_time;
        logic                last;
    } t_out_item;

    typedef struct packed {
        logic [CLIENT_W-1:0] client;
        logic [DELAY_W-1:0]  period;
        logic [TIME_W-1:0]   due;
    } t_slot;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_READ,
        S_EVAL,
        S_FLUSH,
        S_REG,
        S_ERR
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic cap_in;
        logic clk_add;
        logic scan_clr;
        logic idx_inc;
        logic reg_write;
        logic fire;
        logic flush;
        logic err_load;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic table_full;
        logic slot_due;
        logic idx_last;
        logic cnt_last;
        logic pend_valid;
        logic out_free;
    } t_dp_status;

    // Lowest free slot
    function automatic logic [IDX_W-1:0] first_free(input logic [NUM_TIMERS-1:0] in_use);
        logic [IDX_W-1:0] idx;
        logic             found;
        idx   = '0;
        found = 1'b0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (!found && !in_use[i]) begin
                idx   = IDX_W'(i);
                found = 1'b1;
            end
        end
        return idx;
    endfunction

endpackage

// ----- rtl/core/mctt_ctrl.sv -----
module mctt_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_mode,
    input  mctt_pkg::t_dp_status i_status,
    output logic                 o_in_stall,
    output mctt_pkg::t_ctrl_cmd  o_cmd
);

    mctt_pkg::t_state r_state;
    mctt_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mctt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            mctt_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.cap_in = 1'b1;
                    n_state = (i_mode == mctt_pkg::MODE_REG) ? mctt_pkg::S_REG
                                                             : mctt_pkg::S_TICK;
                end
            end
            mctt_pkg::S_TICK: begin
                o_cmd.clk_add  = 1'b1;
                o_cmd.scan_clr = 1'b1;
                n_state        = mctt_pkg::S_READ;
            end
            mctt_pkg::S_READ: begin
                n_state = mctt_pkg::S_EVAL;
            end
            mctt_pkg::S_EVAL: begin
                if (i_status.slot_due) begin
                    // hold while an earlier ping cannot leave
                    if (!i_status.pend_valid || i_status.out_free) begin
                        o_cmd.fire = 1'b1;
                        if (i_status.cnt_last || i_status.idx_last) begin
                            n_state = mctt_pkg::S_FLUSH;
                        end else begin
                            o_cmd.idx_inc = 1'b1;
                            n_state       = mctt_pkg::S_READ;
                        end
                    end
                end else if (i_status.idx_last) begin
                    n_state = mctt_pkg::S_FLUSH;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = mctt_pkg::S_READ;
                end
            end
            mctt_pkg::S_FLUSH: begin
                if (!i_status.pend_valid) begin
                    n_state = mctt_pkg::S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = mctt_pkg::S_IDLE;
                end
            end
            mctt_pkg::S_REG: begin
                if (i_status.table_full) begin
                    n_state = mctt_pkg::S_ERR;
                end else begin
                    o_cmd.reg_write = 1'b1;
                    n_state         = mctt_pkg::S_IDLE;
                end
            end
            mctt_pkg::S_ERR: begin
                if (i_status.out_free) begin
                    o_cmd.err_load = 1'b1;
                    n_state        = mctt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mctt_pkg::S_IDLE;
            end
        endcase
    end

    // No ping is left behind once the block goes idle
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mctt_pkg::S_IDLE) |-> !i_status.pend_valid)
        else $error("pending ping while idle");

    // A slot is only taken when one is free
    a_reg_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.reg_write |-> !i_status.table_full)
        else $error("register into full table");

    // A tick always moves on to the scan's first read; the tick starts it at slot zero with the clock advanced
    a_tick_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mctt_pkg::S_TICK) |=> (r_state == mctt_pkg::S_READ))
        else $error("tick did not start scan");

endmodule

// ----- rtl/core/mctt_dp.sv -----
module mctt_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mctt_pkg::t_ctrl_cmd                 i_cmd,
    input  mctt_pkg::t_in_item                  i_in_item,
    input  logic                                i_cfg_valid,
    input  logic [mctt_pkg::STEP_W-1:0]         i_cfg_data,
    input  logic                                i_out_stall,
    output logic                                o_cfg_ready,
    output logic                                o_out_valid,
    output mctt_pkg::t_out_item                 o_out_item,
    output mctt_pkg::t_dp_status                o_status
);

    logic [mctt_pkg::STEP_W-1:0]     r_tick_step;
    logic [mctt_pkg::TIME_W-1:0]     r_clock;
    logic [mctt_pkg::NUM_TIMERS-1:0] r_in_use;
    mctt_pkg::t_in_item              r_in;
    mctt_pkg::t_slot                 r_mem [mctt_pkg::NUM_TIMERS];
    mctt_pkg::t_slot                 r_rd;
    logic [mctt_pkg::IDX_W-1:0]      r_idx;
    logic [mctt_pkg::CNT_W-1:0]      r_cnt;
    logic                            r_pend_valid;
    logic [mctt_pkg::CLIENT_W-1:0]   r_pend_client;
    logic [mctt_pkg::TIME_W-1:0]     r_pend_due;
    logic                            r_out_valid;
    mctt_pkg::t_out_item             r_out;

    logic [mctt_pkg::IDX_W-1:0]      free_idx;
    logic                            out_free;
    logic [mctt_pkg::TIME_W-1:0]     next_due;
    logic                            wr_en;
    logic [mctt_pkg::IDX_W-1:0]      wr_addr;
    mctt_pkg::t_slot                 wr_data;

    assign o_cfg_ready = 1'b1;
    assign free_idx    = mctt_pkg::first_free(r_in_use);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign next_due    = r_rd.due + {{(mctt_pkg::TIME_W-mctt_pkg::DELAY_W){1'b0}}, r_rd.period};

    // Status towards the controller
    always_comb begin
        o_status.table_full = &r_in_use;
        o_status.slot_due   = r_in_use[r_idx] && (r_clock >= r_rd.due);
        o_status.idx_last   = (r_idx == mctt_pkg::IDX_W'(mctt_pkg::NUM_TIMERS - 1));
        o_status.cnt_last   = (r_cnt == mctt_pkg::CNT_W'(mctt_pkg::MAX_RESULTS - 1));
        o_status.pend_valid = r_pend_valid;
        o_status.out_free   = out_free;
    end

    // Tick step register and millisecond clock
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_step <= mctt_pkg::TICK_STEP_RESET;
            r_clock     <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_tick_step <= i_cfg_data;
            end
            if (i_cmd.clk_add) begin
                r_clock <= r_clock + {{(mctt_pkg::TIME_W-mctt_pkg::STEP_W){1'b0}}, r_tick_step};
            end
        end
    end

    // Capture the input item
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_in <= i_in_item;
        end
    end

    // Scan index and ping count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.scan_clr) begin
                r_idx <= '0;
                r_cnt <= '0;
            end else begin
                if (i_cmd.idx_inc) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (i_cmd.fire) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // Slot occupancy flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0;
        end else begin
            if (i_cmd.reg_write) begin
                r_in_use[free_idx] <= 1'b1;
            end
            if (i_cmd.fire && (r_rd.period == '0)) begin
                r_in_use[r_idx] <= 1'b0;
            end
        end
    end

    // Slot memory write port: new timer or periodic advance
    always_comb begin
        wr_en   = i_cmd.reg_write || (i_cmd.fire && (r_rd.period != '0));
        wr_addr = i_cmd.reg_write ? free_idx : r_idx;
        if (i_cmd.reg_write) begin
            wr_data.client = r_in.client_id;
            wr_data.period = r_in.repeat_req ? r_in.delay_ms : '0;
            wr_data.due    = r_clock
                           + {{(mctt_pkg::TIME_W-mctt_pkg::DELAY_W){1'b0}}, r_in.delay_ms};
        end else begin
            wr_data.client = r_rd.client;
            wr_data.period = r_rd.period;
            wr_data.due    = next_due;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[r_idx];
    end

    // Pending ping: held until the scan shows whether it is the final one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.fire) begin
            r_pend_valid <= 1'b1;
        end else if (i_cmd.flush) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fire) begin
            r_pend_client <= r_rd.client;
            r_pend_due    <= r_rd.due;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.fire && r_pend_valid) || i_cmd.flush || i_cmd.err_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.err_load) begin
            r_out.kind          <= mctt_pkg::KIND_FULL;
            r_out.target_client <= '0;
            r_out.due_time      <= '0;
            r_out.last          <= 1'b1;
        end else if ((i_cmd.fire && r_pend_valid) || i_cmd.flush) begin
            r_out.kind          <= mctt_pkg::KIND_PING;
            r_out.target_client <= r_pend_client;
            r_out.due_time      <= r_pend_due;
            r_out.last          <= i_cmd.flush;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // An item is never loaded over one that is still stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_cmd.fire && r_pend_valid) || i_cmd.flush || i_cmd.err_load) |-> out_free)
        else $error("output overwritten");

    // A one-shot slot is freed after it fires
    a_oneshot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fire && (r_rd.period == '0)) |=> !r_in_use[$past(r_idx)])
        else $error("one-shot slot not freed");

    // Only the flush marks the final ping
    a_last_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fire && r_pend_valid) |=> (o_out_valid && !o_out_item.last))
        else $error("intermediate ping marked final");

endmodule

// ----- rtl/core/multi_channel_alarm_timer_table_unit.sv -----
// Tick item: the clock advances, then the shared slot memory is read and evaluated one slot
// at a time up to the last slot or the result limit, and a flush sends the final ping.
// Register item: a free slot is taken, or a table-full error item is sent once the output is free.
// One item is handled at a time; output stalls extend the scan while pings back up.
// Reset (synchronous, active low) frees every slot, zeroes the clock and sets tick step 5;
// slot contents are not cleared and need no pass after reset.
module multi_channel_alarm_timer_table_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  mctt_pkg::t_in_item          i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output mctt_pkg::t_out_item         o_out_item,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [mctt_pkg::STEP_W-1:0] i_cfg_data
);

    mctt_pkg::t_ctrl_cmd  cmd;
    mctt_pkg::t_dp_status status;

    // Sequencer
    mctt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_in_item.mode),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // Clock, slot table and result path
    mctt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_cfg_ready (o_cfg_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .o_status    (status)
    );

endmodule
